@@ src/cqs_pkg.sv @@
// Shared types and constants for the circular queue with search.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cqs_pkg;

  // Number of slots in the queue
  localparam int QUEUE_DEPTH = 16;

  // Width of the internal fill count, wide enough to hold QUEUE_DEPTH itself
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Fixed widths of the item fields
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  // Operation carried by one item
  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_STATUS = 2'd3
  } cqs_mode_t;

  // Per-cycle command to the row of cells
  typedef struct packed {
    logic enq;  // append the key at the first free cell
    logic deq;  // shift every cell one place towards the front
  } cqs_ctrl_t;

endpackage

`default_nettype wire

@@ src/cqs_cell.sv @@
// One storage cell of the queue: holds an entry and its valid bit.
// Takes its neighbour's entry on a dequeue; depends on cqs_pkg.
`default_nettype none

module cqs_cell
  import cqs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cqs_ctrl_t                ctrl,
  input  wire logic signed [DATA_W-1:0] key,
  input  wire logic                     prev_valid,
  input  wire logic signed [DATA_W-1:0] nxt_data,
  input  wire logic                     nxt_valid,
  output logic signed [DATA_W-1:0]      data,
  output logic                          valid,
  output logic                          match
);

  logic take_key;

  // This cell is the first free slot when it is empty and its front neighbour is not
  assign take_key = ctrl.enq && !valid && prev_valid;

  // Hold the valid bit, advance it on a dequeue, set it when the key lands here
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.deq) begin
      valid <= nxt_valid;
    end else if (take_key) begin
      valid <= 1'b1;
    end
  end

  // Entry itself carries no reset
  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      data <= nxt_data;
    end else if (take_key) begin
      data <= key;
    end
  end

  // Compare against the search key, only when the entry is live
  assign match = valid && (data == key);

endmodule

`default_nettype wire

@@ src/cqs_chain.sv @@
// Row of QUEUE_DEPTH storage cells, front of the queue at cell 0.
// Instantiates cqs_cell; depends on cqs_pkg.
`default_nettype none

module cqs_chain
  import cqs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cqs_ctrl_t                ctrl,
  input  wire logic signed [DATA_W-1:0] key,
  output logic signed [DATA_W-1:0]      head_data,
  output logic signed [DATA_W-1:0]      second_data,
  output logic [QUEUE_DEPTH-1:0]        match
);

  logic signed [DATA_W-1:0] cell_data  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_valid;

  // Build the row; each cell sees the valid bit in front and the entry behind
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     prev_v;
    logic signed [DATA_W-1:0] nxt_d;
    logic                     nxt_v;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt_d = '0;
      assign nxt_v = 1'b0;
    end else begin : g_inner
      assign nxt_d = cell_data[i+1];
      assign nxt_v = cell_valid[i+1];
    end

    cqs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key        (key),
      .prev_valid (prev_v),
      .nxt_data   (nxt_d),
      .nxt_valid  (nxt_v),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .match      (match[i])
    );
  end

  // Front entry now and the one that becomes front after a dequeue
  assign head_data   = cell_data[0];
  assign second_data = cell_data[1];

endmodule

`default_nettype wire

@@ src/circular_queue_with_search.sv @@
// Top level of the circular queue with search: control, fill count, result register.
// Instantiates cqs_chain; depends on cqs_pkg.
`default_nettype none

// A first-in first-out queue of QUEUE_DEPTH signed 32-bit entries that also
// answers membership searches. Each request item carries one operation (enqueue,
// dequeue, search or status) and gives exactly one response item showing the
// queue after the operation. Entries live in a row of cells with the oldest
// entry in the first cell; a dequeue shifts the whole row by one place and a
// search compares every cell with the key at once. The response is registered
// and appears the cycle after the request is accepted, and a new request is
// taken every cycle while responses are being drained. While a response waits
// under stall, requests are stalled. An enqueue on a full queue is dropped and a
// dequeue on an empty one is ignored, both flagged by error. Front and back read
// as 0 when empty.
module circular_queue_with_search
  import cqs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output logic                          req_stall,
  input  wire logic [1:0]               mode,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          rsp_valid,
  input  wire logic                     rsp_stall,
  output logic signed [DATA_W-1:0]      front_value,
  output logic signed [DATA_W-1:0]      back_value,
  output logic                          found,
  output logic [COUNT_W-1:0]            entry_count,
  output logic                          is_empty,
  output logic                          is_full,
  output logic                          error
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  cqs_mode_t                op;
  logic                     accept;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic signed [DATA_W-1:0] back;
  logic                     q_empty;
  logic                     q_full;
  logic                     enq_ok;
  logic                     deq_ok;
  cqs_ctrl_t                ctrl;
  logic signed [DATA_W-1:0] head_data;
  logic signed [DATA_W-1:0] second_data;
  logic [QUEUE_DEPTH-1:0]   match;
  logic signed [DATA_W-1:0] front_next;
  logic signed [DATA_W-1:0] back_next;
  logic                     found_next;
  logic                     error_next;

  // Handshake: stall requests while a response is held
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign op        = cqs_mode_t'(mode);

  assign q_empty = (count == '0);
  assign q_full  = (count == CNT_FULL);
  assign enq_ok  = accept && (op == MODE_ENQ) && !q_full;
  assign deq_ok  = accept && (op == MODE_DEQ) && !q_empty;

  assign ctrl.enq = enq_ok;
  assign ctrl.deq = deq_ok;

  cqs_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .key         (value),
    .head_data   (head_data),
    .second_data (second_data),
    .match       (match)
  );

  // Work out the queue as it stands after this item
  always_comb begin
    count_next = count;
    front_next = q_empty ? '0 : head_data;
    back_next  = q_empty ? '0 : back;
    if (enq_ok) begin
      count_next = count + CNT_ONE;
      back_next  = value;
      if (q_empty) begin
        front_next = value;
      end
    end else if (deq_ok) begin
      count_next = count - CNT_ONE;
      if (count == CNT_ONE) begin
        front_next = '0;
        back_next  = '0;
      end else begin
        front_next = second_data;
      end
    end
  end

  assign found_next = (op == MODE_SEARCH) && (|match);
  assign error_next = ((op == MODE_ENQ) && q_full) || ((op == MODE_DEQ) && q_empty);

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (enq_ok || deq_ok) begin
      count <= count_next;
    end
  end

  // Newest entry, kept beside the row so no selection by count is needed
  always_ff @(posedge clk) begin
    if (enq_ok) begin
      back <= value;
    end
  end

  // Response valid: set on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      front_value <= front_next;
      back_value  <= back_next;
      found       <= found_next;
      entry_count <= COUNT_W'(count_next);
      is_empty    <= (count_next == '0);
      is_full     <= (count_next == CNT_FULL);
      error       <= error_next;
    end
  end

endmodule

`default_nettype wire

@@ src/cqs_chk.sv @@
// Port-level checks for the circular queue with search, bound to the top level.
// Depends on cqs_pkg and circular_queue_with_search.
`default_nettype none

module cqs_chk
  import cqs_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     req_valid,
  input wire logic                     req_stall,
  input wire logic [1:0]               mode,
  input wire logic                     rsp_valid,
  input wire logic                     rsp_stall,
  input wire logic signed [DATA_W-1:0] front_value,
  input wire logic signed [DATA_W-1:0] back_value,
  input wire logic                     found,
  input wire logic [COUNT_W-1:0]       entry_count,
  input wire logic                     is_empty,
  input wire logic                     is_full,
  input wire logic                     error
);

  // Every accepted item gives a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> rsp_valid)
    else $error("no response after an accepted item");

  // Search and status never flag an error
  a_no_err: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (mode == MODE_SEARCH || mode == MODE_STATUS))
      |=> !error)
    else $error("error raised outside enqueue or dequeue");

  // An empty queue shows zero count and zero front and back
  a_empty_view: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && is_empty) |->
      (entry_count == '0 && front_value == '0 && back_value == '0 && !is_full))
    else $error("empty response with live contents");

  // A found flag needs a non-empty queue
  a_found_live: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && found) |-> !is_empty)
    else $error("found on an empty queue");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(entry_count)))
    else $error("stalled response changed");

endmodule

bind circular_queue_with_search cqs_chk u_cqs_chk (.*);

`default_nettype wire
